@@ hw/rtl/rpc_pkg.sv @@
// Shared types and constants for the rectangle polygon clipper
`timescale 1ns / 1ps
package rpc_pkg;
    localparam int NUM_STAGES = 4;
    localparam int MAX_VERTS  = 32;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        CFG_X_MIN = 2'd0,
        CFG_Y_MIN = 2'd1,
        CFG_X_MAX = 2'd2,
        CFG_Y_MAX = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STG_LEFT   = 2'd0,
        STG_RIGHT  = 2'd1,
        STG_BOTTOM = 2'd2,
        STG_TOP    = 2'd3
    } stage_t;
endpackage

@@ hw/rtl/rpc_stream_if.sv @@
// Valid/ready channel carrying one request payload
`timescale 1ns / 1ps
interface rpc_stream_if #(parameter int PW = 21);
    logic          valid;
    logic          ready;
    logic [PW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/rect_polygon_clipper_unit.sv @@
// Top level of the rectangle polygon clipper
//  channel   | dir | payload
//  in_ch     | in  | vertex_x, vertex_y, last_vertex
//  out_ch    | out | out_x, out_y, vertex_present, end_of_polygon
//  cfg       | in  | cfg_we, cfg_idx, cfg_data
// Each point is accepted from the queue and then walks the stages in turn; outputs are registered.
// Each boundary crossing is computed in the shared bit-serial divider.
// Closing visits each stage and its closing crossing, then emits the terminator.
// Reset clears the queue, the stage flags and the window to its full extent.
// The input queue keeps accepting, until its four entries are full, while the engine waits on a stalled output.
`timescale 1ns / 1ps
module rect_polygon_clipper_unit #(
    parameter int COORD_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_idx,
    input  logic [COORD_BITS-1:0] cfg_data,
    rpc_stream_if.sink            in_ch,
    rpc_stream_if.source          out_ch
);
    rpc_stream_if #(.PW(2*COORD_BITS+1)) q_ch ();

    rpc_front #(.PW(2*COORD_BITS+1), .DEPTH(4)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_ch(q_ch.source)
    );

    rpc_back #(.CB(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .q_ch(q_ch.sink), .out_ch(out_ch)
    );

    a_term_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data[0]) |-> !out_ch.data[1])
        else $error("terminator carries a vertex");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("result dropped under stall");
endmodule

@@ hw/rtl/rpc_divider.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands
`timescale 1ns / 1ps
module rpc_divider #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic          rem_nz
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   sh;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = {r_reg[DW-1:0], q_reg[NW-1]};
        if (busy_reg)
        begin
            if (sh >= {1'b0, d_reg})
            begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = sh;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (!busy_reg && start)
            d_reg <= den;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign quot   = q_reg;
    assign rem_nz = |r_reg;
endmodule

@@ hw/rtl/rpc_front.sv @@
// Input side: accept vertices and queue them for the clipping engine
`timescale 1ns / 1ps
module rpc_front #(
    parameter int PW    = 21,
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    rpc_stream_if.sink   in_ch,
    rpc_stream_if.source q_ch
);
    localparam int AW = $clog2(DEPTH);
    logic [PW-1:0] mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ch.ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_ch.valid  = (cnt_reg != '0);
    assign pop         = q_ch.valid && q_ch.ready;
    assign q_ch.data   = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= in_ch.data;
    end
endmodule

@@ hw/rtl/rpc_back.sv @@
// Clipping engine: walks each vertex through the four boundary stages
`timescale 1ns / 1ps
module rpc_back #(
    parameter int CB = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_idx,
    input  logic [CB-1:0] cfg_data,
    rpc_stream_if.sink    q_ch,
    rpc_stream_if.source  out_ch
);
    localparam int NS = rpc_pkg::NUM_STAGES;
    localparam int NW = 2 * CB + 2;
    localparam int DW = CB + 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PROC  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_EMIT  = 6'b001000,
        ST_CLOSE = 6'b010000,
        ST_TERM  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        PH_CROSS = 2'd0,
        PH_PASS  = 2'd1,
        PH_CLOSE = 2'd2
    } phase_t;

    state_t state_reg;
    logic [CB-1:0] xmin_reg, ymin_reg, xmax_reg, ymax_reg;
    logic [CB-1:0] fx_reg [NS];
    logic [CB-1:0] fy_reg [NS];
    logic [CB-1:0] px_reg [NS];
    logic [CB-1:0] py_reg [NS];
    logic [NS-1:0] has_reg;
    logic [CB-1:0] sx_reg [NS+1];
    logic [CB-1:0] sy_reg [NS+1];
    logic [2:0]    lvl_reg;
    phase_t        ph_reg [NS+1];
    logic          last_reg;
    logic [1:0]    cs_reg;
    logic [5:0]    ocnt_reg;
    logic [CB-1:0] ox_reg, oy_reg;
    logic          opres_reg, oend_reg, ovalid_reg;
    logic [CB-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic          xneg_reg, dneg_reg;
    logic [1:0]    ds_reg;
    logic [2:0]    dl_reg;

    logic          dv_start, dv_busy, dv_done, dv_rem_nz;
    logic [NW-1:0] dv_num, dv_quot;
    logic [DW-1:0] dv_den;

    rpc_divider #(.NW(NW), .DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
        .busy(dv_busy), .done(dv_done), .quot(dv_quot), .rem_nz(dv_rem_nz)
    );

    function automatic logic inside_f(input logic [1:0] s, input logic [CB-1:0] x,
                                      input logic [CB-1:0] y, input logic [CB-1:0] xl,
                                      input logic [CB-1:0] xh, input logic [CB-1:0] yl,
                                      input logic [CB-1:0] yh);
        case (s)
            rpc_pkg::STG_LEFT:   return x >= xl;
            rpc_pkg::STG_RIGHT:  return x <= xh;
            rpc_pkg::STG_BOTTOM: return y >= yl;
            default:             return y <= yh;
        endcase
    endfunction

    logic [1:0]    cur_s;
    logic [CB-1:0] cx, cy, bnd, a_lo, b_lo, a_hi, b_hi;
    logic          in_p, in_c, in_f;
    logic [CB:0]   dden_s;
    logic          out_free;
    logic [2:0]    nlvl, dl_nx;
    logic          emit_v;

    assign out_free = !ovalid_reg || out_ch.ready;
    assign cur_s    = lvl_reg[1:0];
    assign nlvl     = lvl_reg + 3'd1;
    assign dl_nx    = dl_reg + 3'd1;
    assign cx       = sx_reg[lvl_reg];
    assign cy       = sy_reg[lvl_reg];
    assign in_c     = inside_f(cur_s, cx, cy, xmin_reg, xmax_reg, ymin_reg, ymax_reg);
    assign in_p     = inside_f(cur_s, px_reg[cur_s], py_reg[cur_s],
                               xmin_reg, xmax_reg, ymin_reg, ymax_reg);
    assign in_f     = inside_f(cs_reg, fx_reg[cs_reg], fy_reg[cs_reg],
                               xmin_reg, xmax_reg, ymin_reg, ymax_reg);
    assign emit_v   = out_free && (((state_reg == ST_PROC) && (lvl_reg == 3'(NS))
                      && (ocnt_reg != 6'(rpc_pkg::MAX_VERTS))) || (state_reg == ST_TERM));

    always_comb
    begin
        case (ds_reg)
            rpc_pkg::STG_LEFT:   bnd = xmin_reg;
            rpc_pkg::STG_RIGHT:  bnd = xmax_reg;
            rpc_pkg::STG_BOTTOM: bnd = ymin_reg;
            default:             bnd = ymax_reg;
        endcase
        if (!ds_reg[1])
        begin
            a_lo = ax_reg; b_lo = bx_reg; a_hi = ay_reg; b_hi = by_reg;
        end
        else
        begin
            a_lo = ay_reg; b_lo = by_reg; a_hi = ax_reg; b_hi = bx_reg;
        end
    end

    logic [CB:0]   t1, t2, abs1, abs2, absd;
    logic [NW-1:0] prod;
    assign t1     = {1'b0, bnd} - {1'b0, a_lo};
    assign t2     = {1'b0, b_hi} - {1'b0, a_hi};
    assign dden_s = {1'b0, b_lo} - {1'b0, a_lo};
    assign abs1   = t1[CB] ? -t1 : t1;
    assign abs2   = t2[CB] ? -t2 : t2;
    assign absd   = dden_s[CB] ? -dden_s : dden_s;
    assign prod   = NW'(abs1) * NW'(abs2);

    assign dv_num   = prod;
    assign dv_den   = absd;
    assign dv_start = (state_reg == ST_DIV) && !dv_busy && !dv_done;

    logic [NW-1:0] q_adj;
    logic [NW:0]   rel;
    logic [CB-1:0] ix, iy;
    always_comb
    begin
        q_adj = dv_quot;
        if ((xneg_reg ^ dneg_reg) && dv_rem_nz)
            q_adj = dv_quot + 1'b1;
        if (xneg_reg ^ dneg_reg)
            rel = {1'b0, NW'(a_hi)} - {1'b0, q_adj};
        else
            rel = {1'b0, NW'(a_hi)} + {1'b0, q_adj};
        if (!ds_reg[1])
        begin
            ix = bnd; iy = rel[CB-1:0];
        end
        else
        begin
            iy = bnd; ix = rel[CB-1:0];
        end
    end

    assign q_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.data    = {ox_reg, oy_reg, opres_reg, oend_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            has_reg    <= '0;
            ovalid_reg <= 1'b0;
            xmin_reg   <= '0;
            ymin_reg   <= '0;
            xmax_reg   <= CB'(1023);
            ymax_reg   <= CB'(1023);
            lvl_reg    <= '0;
            ocnt_reg   <= '0;
            cs_reg     <= '0;
            last_reg   <= 1'b0;
            for (int i = 0; i <= NS; i++)
                ph_reg[i] <= PH_CROSS;
        end
        else
        begin
            if (emit_v)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_idx)
                    rpc_pkg::CFG_X_MIN: xmin_reg <= cfg_data;
                    rpc_pkg::CFG_Y_MIN: ymin_reg <= cfg_data;
                    rpc_pkg::CFG_X_MAX: xmax_reg <= cfg_data;
                    default:            ymax_reg <= cfg_data;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_ch.valid)
                    begin
                        sx_reg[0] <= q_ch.data[2*CB:CB+1];
                        sy_reg[0] <= q_ch.data[CB:1];
                        last_reg  <= q_ch.data[0];
                        lvl_reg   <= '0;
                        ph_reg[0] <= PH_CROSS;
                        ocnt_reg  <= '0;
                        state_reg <= ST_PROC;
                    end
                end
                ST_PROC:
                begin
                    if (lvl_reg == 3'(NS))
                    begin
                        if (out_free)
                        begin
                            if (ocnt_reg != 6'(rpc_pkg::MAX_VERTS))
                            begin
                                ox_reg     <= cx;
                                oy_reg     <= cy;
                                opres_reg  <= 1'b1;
                                oend_reg   <= 1'b0;
                                ocnt_reg   <= ocnt_reg + 1'b1;
                            end
                            state_reg <= ST_EMIT;
                        end
                    end
                    else if (ph_reg[lvl_reg] == PH_CROSS)
                    begin
                        ph_reg[lvl_reg] <= PH_PASS;
                        if (!has_reg[cur_s])
                        begin
                            has_reg[cur_s] <= 1'b1;
                            fx_reg[cur_s]  <= cx;
                            fy_reg[cur_s]  <= cy;
                        end
                        else if (in_p != in_c)
                        begin
                            ax_reg <= px_reg[cur_s]; ay_reg <= py_reg[cur_s];
                            bx_reg <= cx; by_reg <= cy;
                            ds_reg <= cur_s; dl_reg <= lvl_reg;
                            state_reg <= ST_DIV;
                        end
                    end
                    else if (ph_reg[lvl_reg] == PH_PASS)
                    begin
                        px_reg[cur_s]   <= cx;
                        py_reg[cur_s]   <= cy;
                        ph_reg[lvl_reg] <= PH_CLOSE;
                        if (in_c)
                        begin
                            sx_reg[nlvl] <= cx;
                            sy_reg[nlvl] <= cy;
                            ph_reg[nlvl] <= PH_CROSS;
                            lvl_reg      <= nlvl;
                        end
                    end
                    else
                        state_reg <= ST_EMIT;
                end
                ST_DIV:
                begin
                    xneg_reg <= t1[CB] ^ t2[CB];
                    dneg_reg <= dden_s[CB];
                    if (dv_done)
                    begin
                        sx_reg[dl_nx] <= ix;
                        sy_reg[dl_nx] <= iy;
                        ph_reg[dl_nx] <= PH_CROSS;
                        lvl_reg       <= dl_nx;
                        state_reg     <= ST_PROC;
                    end
                end
                ST_EMIT:
                begin
                    if (lvl_reg == 3'(NS))
                    begin
                        lvl_reg   <= lvl_reg - 1'b1;
                        state_reg <= ST_PROC;
                    end
                    else if (last_reg && !has_reg[cs_reg] && lvl_reg == {1'b0, cs_reg})
                    begin
                        if (cs_reg == 2'(NS-1))
                            state_reg <= ST_TERM;
                        else
                        begin
                            cs_reg    <= cs_reg + 1'b1;
                            state_reg <= ST_CLOSE;
                        end
                    end
                    else if (lvl_reg == '0)
                    begin
                        if (last_reg)
                        begin
                            cs_reg    <= '0;
                            state_reg <= ST_CLOSE;
                        end
                        else
                            state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        lvl_reg   <= lvl_reg - 1'b1;
                        state_reg <= ST_PROC;
                    end
                end
                ST_CLOSE:
                begin
                    if (has_reg[cs_reg] && in_f != inside_f(cs_reg, px_reg[cs_reg],
                        py_reg[cs_reg], xmin_reg, xmax_reg, ymin_reg, ymax_reg))
                    begin
                        ax_reg <= px_reg[cs_reg]; ay_reg <= py_reg[cs_reg];
                        bx_reg <= fx_reg[cs_reg]; by_reg <= fy_reg[cs_reg];
                        ds_reg <= cs_reg; dl_reg <= {1'b0, cs_reg};
                        ph_reg[cs_reg] <= PH_CLOSE;
                        last_reg  <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                    else if (cs_reg == 2'(NS-1))
                        state_reg <= ST_TERM;
                    else
                        cs_reg <= cs_reg + 1'b1;
                    has_reg[cs_reg] <= 1'b0;
                end
                ST_TERM:
                begin
                    if (out_free)
                    begin
                        ox_reg     <= '0;
                        oy_reg     <= '0;
                        opres_reg  <= 1'b0;
                        oend_reg   <= 1'b1;
                        has_reg    <= '0;
                        last_reg   <= 1'b0;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
